// File: rtl/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue
// no dependencies; imported by spq_ctrl, spq_datapath, sorted_priority_queue and the testbench
package spq_pkg;

  localparam int PRIO_W    = 16;
  localparam int WORD_W    = 32;
  localparam int EXT_W     = 64;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_CHG = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_REPORT = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    enq;
    logic    deq;
    logic    chg;
    status_t status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

// File: rtl/spq_ctrl.sv
// spq_ctrl: accept/report state machine, decodes the operation into datapath commands
// depends on spq_pkg
module spq_ctrl
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy,
  output logic       out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = ST_OK;
    busy       = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_REPORT;
          case (op_t'(in_op))
            OP_ENQ: begin
              if (stat.full) cmd.status = ST_FULL;
              else cmd.enq = 1'b1;
            end
            OP_DEQ: begin
              if (stat.empty) cmd.status = ST_EMPTY;
              else cmd.deq = 1'b1;
            end
            OP_CHG: begin
              cmd.chg = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_REPORT: begin
        busy      = 1'b1;
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/spq_datapath.sv
// spq_datapath: row of compare-and-shift cells, fill count and result registers
// depends on spq_pkg
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  logic [WORD_W-1:0]        in_data,
  input  logic signed [PRIO_W-1:0] in_priority_req,
  input  logic signed [PRIO_W-1:0] in_amount,
  output stat_t                    stat,
  output logic [WORD_W-1:0]        out_data,
  output logic signed [PRIO_W-1:0] out_priority,
  output logic [WORD_W-1:0]        out_head_data,
  output logic signed [PRIO_W-1:0] out_head_priority,
  output logic [CNT_W-1:0]         out_count,
  output logic [1:0]               out_status
);

  logic [DATA_WIDTH-1:0]    cell_data_r [CAPACITY];
  logic signed [PRIO_W-1:0] cell_prio_r [CAPACITY];
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [DATA_WIDTH-1:0]    res_data_r, res_data_nxt;
  logic signed [PRIO_W-1:0] res_prio_r, res_prio_nxt;
  status_t                  status_r, status_nxt;

  logic [CAPACITY-1:0]      le;
  logic [EXT_W-1:0]         in_ext, res_ext, head_ext;
  logic [DATA_WIDTH-1:0]    new_data;

  assign in_ext   = EXT_W'(in_data);
  assign new_data = in_ext[DATA_WIDTH-1:0];

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == CNT_W'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0]    data_nxt;
    logic signed [PRIO_W-1:0] prio_nxt;
    logic signed [PRIO_W:0]   sum;
    logic signed [PRIO_W-1:0] sat;

    // held entry that stays in front of the new one
    assign le[i] = (fill_r > CNT_W'(i)) && (cell_prio_r[i] <= in_priority_req);

    assign sum = {cell_prio_r[i][PRIO_W-1], cell_prio_r[i]}
               + {in_amount[PRIO_W-1], in_amount};
    assign sat = (sum[PRIO_W] != sum[PRIO_W-1])
               ? (sum[PRIO_W] ? {1'b1, {(PRIO_W-1){1'b0}}} : {1'b0, {(PRIO_W-1){1'b1}}})
               : sum[PRIO_W-1:0];

    always_comb begin
      data_nxt = cell_data_r[i];
      prio_nxt = cell_prio_r[i];
      if (cmd.enq) begin
        if (!le[i]) begin
          if (i == 0) begin
            data_nxt = new_data;
            prio_nxt = in_priority_req;
          end else if (le[(i == 0) ? 0 : i - 1]) begin
            data_nxt = new_data;
            prio_nxt = in_priority_req;
          end else begin
            data_nxt = cell_data_r[(i == 0) ? 0 : i - 1];
            prio_nxt = cell_prio_r[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (cmd.deq) begin
        if (i < CAPACITY - 1) begin
          data_nxt = cell_data_r[(i < CAPACITY - 1) ? i + 1 : i];
          prio_nxt = cell_prio_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end else if (cmd.chg) begin
        prio_nxt = sat;
      end
    end

    always_ff @(posedge clk) begin
      cell_data_r[i] <= data_nxt;
      cell_prio_r[i] <= prio_nxt;
    end
  end

  always_comb begin
    fill_nxt     = fill_r;
    res_data_nxt = res_data_r;
    res_prio_nxt = res_prio_r;
    status_nxt   = status_r;
    if (cmd.enq) fill_nxt = fill_r + 1'b1;
    if (cmd.deq) fill_nxt = fill_r - 1'b1;
    if (cmd.load) begin
      res_data_nxt = cmd.deq ? cell_data_r[0] : '0;
      res_prio_nxt = cmd.deq ? cell_prio_r[0] : '0;
      status_nxt   = cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_data_r <= res_data_nxt;
    res_prio_r <= res_prio_nxt;
    status_r   <= status_nxt;
  end

  assign res_ext  = EXT_W'(res_data_r);
  assign head_ext = stat.empty ? '0 : EXT_W'(cell_data_r[0]);

  assign out_data          = res_ext[WORD_W-1:0];
  assign out_priority      = res_prio_r;
  assign out_head_data     = head_ext[WORD_W-1:0];
  assign out_head_priority = stat.empty ? '0 : cell_prio_r[0];
  assign out_count         = fill_r;
  assign out_status        = status_r;

endmodule

// File: rtl/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue kept sorted in a row of shift cells
// the result word strobes on out_valid in the cycle after start is taken
// a new word waits out the controller's report state for the last one; busy is high during it
// every cell compares, shifts or adds in the accept cycle, whatever the queue depth
// reset (rst_n low, synchronous) empties the queue; cell contents stay undefined
// out_valid lasts one cycle and the receiver cannot stall it
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic [WORD_W-1:0]             in_data,
  input  logic signed [PRIO_W-1:0]      in_priority_req,
  input  logic signed [PRIO_W-1:0]      in_amount,
  // result side
  output logic                          out_valid,
  output logic [WORD_W-1:0]             out_data,
  output logic signed [PRIO_W-1:0]      out_priority,
  output logic [WORD_W-1:0]             out_head_data,
  output logic signed [PRIO_W-1:0]      out_head_priority,
  output logic [$clog2(CAPACITY+1)-1:0] out_count,
  output logic [1:0]                    out_status
);

  // fill count has to hold the value CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // commands go out in the accept cycle; full/empty come back from the fill count
  cmd_t  cmd;
  stat_t stat;

  // controller: idle waits for start, report shows the word for one cycle
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath: enqueue inserts behind every entry with priority <= the new one,
  // dequeue shifts everything toward the head, change adds with saturation
  spq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_data           (in_data),
    .in_priority_req   (in_priority_req),
    .in_amount         (in_amount),
    .stat              (stat),
    .out_data          (out_data),
    .out_priority      (out_priority),
    .out_head_data     (out_head_data),
    .out_head_priority (out_head_priority),
    .out_count         (out_count),
    .out_status        (out_status)
  );

endmodule

// File: verif/tb_sorted_priority_queue.sv
// tb_sorted_priority_queue: self-checking testbench for the sorted priority queue
// directed table then weighted random traffic, results checked vs. local mirror or typed rows
// depends on spq_pkg and the sorted_priority_queue rtl
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int QDEPTH       = 16;
  localparam int CNT_BITS     = $clog2(QDEPTH + 1);
  localparam int RANDOM_WORDS = 1350;
  localparam int SETTLE_CYCLES = 4;

  // one result word as seen on the out_ ports
  typedef struct packed {
    logic [WORD_W-1:0]        data;
    logic signed [PRIO_W-1:0] prio;
    logic [WORD_W-1:0]        head_data;
    logic signed [PRIO_W-1:0] head_prio;
    logic [CNT_BITS-1:0]      count;
    status_t                  status;
  } result_t;

  // one command word plus an optional hand-typed expectation
  typedef struct {
    op_t                      op;
    logic [WORD_W-1:0]        data;
    logic signed [PRIO_W-1:0] preq;
    logic signed [PRIO_W-1:0] amt;
    bit                       typed;
    result_t                  want;
  } cmd_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_op = OP_NOP;
  logic [WORD_W-1:0]        in_data = '0;
  logic signed [PRIO_W-1:0] in_priority_req = '0;
  logic signed [PRIO_W-1:0] in_amount = '0;
  logic                     out_valid;
  logic [WORD_W-1:0]        out_data;
  logic signed [PRIO_W-1:0] out_priority;
  logic [WORD_W-1:0]        out_head_data;
  logic signed [PRIO_W-1:0] out_head_priority;
  logic [CNT_BITS-1:0]      out_count;
  logic [1:0]               out_status;

  // typed expectation travels alongside the command word it belongs to
  bit      row_typed = 1'b0;
  result_t row_want = '0;

  // mirror of the queue contents, kept sorted by ascending priority
  logic [WORD_W-1:0]        mirror_data [QDEPTH];
  logic signed [PRIO_W-1:0] mirror_prio [QDEPTH];
  int                       mirror_fill = 0;

  result_t  pending_results[$];
  cmd_row_t directed_rows[$];
  int       fail_count = 0;

  sorted_priority_queue #(
    .CAPACITY  (QDEPTH),
    .DATA_WIDTH(WORD_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_data          (in_data),
    .in_priority_req  (in_priority_req),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_data         (out_data),
    .out_priority     (out_priority),
    .out_head_data    (out_head_data),
    .out_head_priority(out_head_priority),
    .out_count        (out_count),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one command to the mirror and returns the word the block should report
  function automatic result_t predict_queue_op(op_t op, logic [WORD_W-1:0] data,
                                               logic signed [PRIO_W-1:0] preq,
                                               logic signed [PRIO_W-1:0] amt);
    result_t r;
    int pos;
    int sum;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ENQ: begin
        if (mirror_fill >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          // equal priorities keep arrival order: skip past every entry <= new one
          pos = 0;
          while (pos < mirror_fill && mirror_prio[pos] <= preq) pos++;
          for (int i = mirror_fill; i > pos; i--) begin
            mirror_data[i] = mirror_data[i-1];
            mirror_prio[i] = mirror_prio[i-1];
          end
          mirror_data[pos] = data;
          mirror_prio[pos] = preq;
          mirror_fill++;
        end
      end
      OP_DEQ: begin
        if (mirror_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = mirror_data[0];
          r.prio = mirror_prio[0];
          for (int i = 1; i < mirror_fill; i++) begin
            mirror_data[i-1] = mirror_data[i];
            mirror_prio[i-1] = mirror_prio[i];
          end
          mirror_fill--;
        end
      end
      OP_CHG: begin
        // saturating add keeps the order intact
        for (int i = 0; i < mirror_fill; i++) begin
          sum = int'(mirror_prio[i]) + int'(amt);
          if (sum > 32767) sum = 32767;
          else if (sum < -32768) sum = -32768;
          mirror_prio[i] = sum[PRIO_W-1:0];
        end
      end
      default: ;  // unused op code does nothing but report the peek
    endcase
    if (mirror_fill > 0) begin
      r.head_data = mirror_data[0];
      r.head_prio = mirror_prio[0];
    end
    r.count = mirror_fill[CNT_BITS-1:0];
    return r;
  endfunction

  function automatic void add_row(op_t op, logic [WORD_W-1:0] data,
                                  logic signed [PRIO_W-1:0] preq,
                                  logic signed [PRIO_W-1:0] amt,
                                  bit typed = 1'b0, result_t want = '0);
    cmd_row_t row;
    row.op    = op;
    row.data  = data;
    row.preq  = preq;
    row.amt   = amt;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // random command; mode biases toward filling, draining or a mix
  function automatic cmd_row_t random_row(int mode);
    cmd_row_t row;
    int r;
    r = $urandom_range(99);
    case (mode)
      0:       row.op = (r < 65) ? OP_ENQ : (r < 85) ? OP_DEQ : (r < 97) ? OP_CHG : OP_NOP;
      1:       row.op = (r < 20) ? OP_ENQ : (r < 85) ? OP_DEQ : (r < 97) ? OP_CHG : OP_NOP;
      default: row.op = (r < 42) ? OP_ENQ : (r < 82) ? OP_DEQ : (r < 97) ? OP_CHG : OP_NOP;
    endcase
    row.data = $urandom;
    // priorities: full range, a narrow band for many ties, or the limits
    r = $urandom_range(99);
    if (r < 45)      row.preq = $urandom;
    else if (r < 85) row.preq = $signed($urandom_range(8)) - 16'sd4;
    else             row.preq = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    // amounts: mostly small steps, sometimes anything, sometimes the limits
    r = $urandom_range(99);
    if (r < 60)      row.amt = $signed($urandom_range(64)) - 16'sd32;
    else if (r < 85) row.amt = $urandom;
    else             row.amt = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // mostly back to back or short gaps, now and then a long pause
  function automatic int gap_cycles(bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drives one command word, holds it until taken, then idles for a random gap that may be zero
  task automatic send_word(cmd_row_t row, bit no_idle);
    int gap;
    start           <= 1'b1;
    in_op           <= row.op;
    in_data         <= row.data;
    in_priority_req <= row.preq;
    in_amount       <= row.amt;
    row_typed       <= row.typed;
    row_want        <= row.want;
    do @(posedge clk); while (busy);
    gap = gap_cycles(no_idle);
    if (gap > 0) begin
      // junk on the fields while start is low must be ignored
      start           <= 1'b0;
      in_op           <= $urandom;
      in_data         <= $urandom;
      in_priority_req <= $urandom;
      in_amount       <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // stimulus: directed table first, then random bursts
  initial begin : stimulus
    int mode;
    int burst_left;
    bit no_idle;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: dequeue flags, change and unused op leave everything at zero
    add_row(OP_DEQ, 32'h0, 16'sd0, 16'sd0, 1'b1, '{0, 0, 0, 0, 0, ST_EMPTY});
    add_row(OP_CHG, 32'h0, 16'sd0, 16'sh8000, 1'b1, '{0, 0, 0, 0, 0, ST_OK});
    add_row(OP_NOP, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF, 1'b1, '{0, 0, 0, 0, 0, ST_OK});
    // extreme data and priorities, lowest goes to the head
    add_row(OP_ENQ, 32'hFFFF_FFFF, 16'sh7FFF, 16'sd0, 1'b1,
            '{32'h0, 16'sd0, 32'hFFFF_FFFF, 16'sh7FFF, 5'd1, ST_OK});
    add_row(OP_ENQ, 32'h0, 16'sh8000, 16'sd0, 1'b1,
            '{32'h0, 16'sd0, 32'h0, 16'sh8000, 5'd2, ST_OK});
    // changes that saturate low, then high
    add_row(OP_CHG, 32'h0, 16'sd0, 16'sh8000);
    add_row(OP_CHG, 32'h0, 16'sd0, 16'sh7FFF);
    add_row(OP_CHG, 32'h0, 16'sd0, 16'sh7FFF);
    // tie with the head: new word lands behind it
    add_row(OP_ENQ, 32'hA5A5_A5A5, 16'sh7FFE, 16'sd0);
    add_row(OP_DEQ, 32'h0, 16'sd0, 16'sd0);
    add_row(OP_NOP, 32'h5A5A_5A5A, 16'sd0, 16'sd0);
    // fill to capacity with ties and front inserts
    for (int i = 0; i < QDEPTH - 2; i++)
      add_row(OP_ENQ, 32'h1000 + i, 16'sd5 - 16'(i / 2), 16'sd0);
    add_row(OP_ENQ, 32'hDEAD_BEEF, 16'sh8000, 16'sd0);
    add_row(OP_CHG, 32'h0, 16'sd0, 16'sh8000);

    foreach (directed_rows[i]) send_word(directed_rows[i], 1'b0);

    // random bursts of 32 words, each with its own mix and idle behavior
    burst_left = 0;
    mode = 2;
    no_idle = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        burst_left = 32;
        mode = $urandom_range(2);
        no_idle = ($urandom_range(3) == 0);
      end
      burst_left--;
      send_word(random_row(mode), no_idle);
    end

    start     <= 1'b0;
    row_typed <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // monitor: predict on every accepted command, check every result strobe
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst_n) begin
      if (start && !busy) begin
        want = predict_queue_op(op_t'(in_op), in_data, in_priority_req, in_amount);
        if (row_typed) want = row_want;
        pending_results.push_back(want);
      end
      if (out_valid) begin
        got = '{out_data, out_priority, out_head_data, out_head_priority, out_count,
                status_t'(out_status)};
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: result word with nothing expected, expected none, got %h",
                   $time, got);
        end else begin
          want = pending_results.pop_front();
          check_field("out_data", want.data, got.data);
          check_field("out_priority", 32'(want.prio), 32'(got.prio));
          check_field("out_head_data", want.head_data, got.head_data);
          check_field("out_head_priority", 32'(want.head_prio), 32'(got.head_prio));
          check_field("out_count", 32'(want.count), 32'(got.count));
          check_field("out_status", 32'(want.status), 32'(got.status));
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
verif/tb_sorted_priority_queue.sv
